FILE: rtl/mrf_pkg.sv
`default_nettype none
package mrf_pkg;

  // Modbus function codes and fixed frame fields
  localparam logic [7:0]  FuncReadHolding   = 8'h03;
  localparam logic [7:0]  FuncWriteMultiple = 8'h10;
  localparam logic [7:0]  WriteByteCount    = 8'h02;
  localparam logic [7:0]  CountHigh         = 8'h00;
  localparam logic [7:0]  CountLow          = 8'h01;

  // CRC-16/MODBUS
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  // Opcode values
  localparam logic        OpRead  = 1'b0;
  localparam logic        OpWrite = 1'b1;

  // Byte position of the final byte per frame type
  localparam logic [3:0]  LastRdIdx = 4'd7;
  localparam logic [3:0]  LastWrIdx = 4'd10;

  // Register map
  localparam logic        RegSlaveAddr = 1'b0;

  typedef struct packed {
    logic        opcode;
    logic [15:0] register_address;
    logic [15:0] write_value;
  } request_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    SEL_ADDR,
    SEL_FUNC,
    SEL_REG_HI,
    SEL_REG_LO,
    SEL_CNT_HI,
    SEL_CNT_LO,
    SEL_BYTE_CNT,
    SEL_VAL_HI,
    SEL_VAL_LO,
    SEL_CRC_LO,
    SEL_CRC_HI
  } byte_sel_e;

  typedef struct packed {
    logic      load;
    logic      emit;
    logic      last;
    byte_sel_e sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_write;
  } dp_status_t;

  // Fold one byte into the CRC, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mrf_ctrl.sv
`default_nettype none
module mrf_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire mrf_pkg::dp_status_t status_i,
  output      logic                busy_o,
  output      mrf_pkg::dp_cmd_t    cmd_o
);
  import mrf_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [3:0]  idx_q, idx_d;
  logic        last;
  logic        load;
  byte_sel_e   sel;

  // Flag the final byte of the current frame
  assign last = (state_q == ST_EMIT) &&
                (status_i.is_write ? (idx_q == LastWrIdx) : (idx_q == LastRdIdx));

  // Take a new request while idle or while the final byte goes out
  assign busy_o = (state_q == ST_EMIT) && !last;
  assign load   = start_i && !busy_o;

  // Map byte position to the field that fills it
  always_comb begin
    case (idx_q)
      4'd0:    sel = SEL_ADDR;
      4'd1:    sel = SEL_FUNC;
      4'd2:    sel = SEL_REG_HI;
      4'd3:    sel = SEL_REG_LO;
      4'd4:    sel = SEL_CNT_HI;
      4'd5:    sel = SEL_CNT_LO;
      4'd6:    sel = status_i.is_write ? SEL_BYTE_CNT : SEL_CRC_LO;
      4'd7:    sel = status_i.is_write ? SEL_VAL_HI : SEL_CRC_HI;
      4'd8:    sel = SEL_VAL_LO;
      4'd9:    sel = SEL_CRC_LO;
      default: sel = SEL_CRC_HI;
    endcase
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    if (load) begin
      state_d = ST_EMIT;
      idx_d   = 4'd0;
    end else if (state_q == ST_EMIT) begin
      if (last) begin
        state_d = ST_IDLE;
        idx_d   = 4'd0;
      end else begin
        idx_d = idx_q + 4'd1;
      end
    end
    cmd_o.load = load;
    cmd_o.emit = (state_q == ST_EMIT);
    cmd_o.last = last;
    cmd_o.sel  = sel;
  end

  // Hold state and byte position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= 4'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastWrIdx)
    else $error("byte position out of range");

  a_load_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (state_q == ST_EMIT) && (idx_q == 4'd0))
    else $error("request load did not restart the frame");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last && !start_i) |=> (state_q == ST_IDLE))
    else $error("frame did not end after its final byte");

  a_crc_hi_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EMIT) && (sel == SEL_CRC_HI)) |-> last)
    else $error("CRC high byte not flagged as final");

endmodule
`default_nettype wire

FILE: rtl/mrf_dp.sv
`default_nettype none
module mrf_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mrf_pkg::request_t   request_i,
  input  wire logic [7:0]          slave_addr_i,
  input  wire mrf_pkg::dp_cmd_t    cmd_i,
  output      mrf_pkg::dp_status_t status_o,
  output      mrf_pkg::result_t    result_o,
  output      logic                result_strobe_o
);
  import mrf_pkg::*;

  request_t    req_q;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  byte_d;
  logic        is_crc;
  result_t     res_q;
  logic        strobe_q;

  assign status_o.is_write = (req_q.opcode == OpWrite);

  // Select the byte for the current position
  always_comb begin
    is_crc = 1'b0;
    case (cmd_i.sel)
      SEL_ADDR:     byte_d = slave_addr_i;
      SEL_FUNC:     byte_d = (req_q.opcode == OpWrite) ? FuncWriteMultiple : FuncReadHolding;
      SEL_REG_HI:   byte_d = req_q.register_address[15:8];
      SEL_REG_LO:   byte_d = req_q.register_address[7:0];
      SEL_CNT_HI:   byte_d = CountHigh;
      SEL_CNT_LO:   byte_d = CountLow;
      SEL_BYTE_CNT: byte_d = WriteByteCount;
      SEL_VAL_HI:   byte_d = req_q.write_value[15:8];
      SEL_VAL_LO:   byte_d = req_q.write_value[7:0];
      SEL_CRC_LO: begin
        byte_d = crc_q[7:0];
        is_crc = 1'b1;
      end
      default: begin
        byte_d = crc_q[15:8];
        is_crc = 1'b1;
      end
    endcase
  end

  // Reseed on load, fold each data byte while emitting
  always_comb begin
    crc_d = crc_q;
    if (cmd_i.load) begin
      crc_d = CrcInit;
    end else if (cmd_i.emit && !is_crc) begin
      crc_d = crc_byte(crc_q, byte_d);
    end
  end

  // Capture the request and advance the CRC
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= request_i;
    end
    crc_q <= crc_d;
    res_q.frame_byte <= byte_d;
    res_q.last_byte  <= cmd_i.last;
  end

  // Strobe each emitted byte for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  assign result_o        = res_q;
  assign result_strobe_o = strobe_q;

endmodule
`default_nettype wire

FILE: rtl/modbus_rtu_request_framer.sv
`default_nettype none
// Modbus RTU request framer. Pulse start with a request while busy is low; the
// frame comes out one byte per clock on result_o, each byte marked by
// result_strobe_o for exactly one cycle, the first byte leaving the output
// register after the request is registered, with last_byte set on the CRC high
// byte. The receiver cannot stall the byte stream, so it must take a byte in
// every strobed cycle. A read request yields 8 bytes and a write request 11;
// the byte sequencer frees busy while the final byte is formed, so a new
// request can follow back to back. The CRC-16/MODBUS is folded in one byte per
// cycle alongside the output. The slave address register (reset 1) sits at
// APB address 0 and should be written only while no frame is in flight.
module modbus_rtu_request_framer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output      logic              busy,
  input  wire mrf_pkg::request_t request_i,
  output      mrf_pkg::result_t  result_o,
  output      logic              result_strobe_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);
  import mrf_pkg::*;

  logic [7:0] slave_addr_q;
  logic       reg_sel;
  logic       cfg_wr;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Decode the register port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == RegSlaveAddr);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? {24'h000000, slave_addr_q} : 32'h0;

  // Hold the slave address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 8'd1;
    end else if (cfg_wr) begin
      slave_addr_q <= pwdata[7:0];
    end
  end

  mrf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .busy_o   (busy),
    .cmd_o    (cmd)
  );

  mrf_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .request_i       (request_i),
    .slave_addr_i    (slave_addr_q),
    .cmd_i           (cmd),
    .status_o        (status),
    .result_o        (result_o),
    .result_strobe_o (result_strobe_o)
  );

endmodule
`default_nettype wire

FILE: verif/tb_modbus_rtu_request_framer.sv
`timescale 1ns / 100ps
module tb_modbus_rtu_request_framer;
  import mrf_pkg::*;

  // Cycles to let pass once the byte queue has drained
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned PhaseCount = 6;
  localparam int unsigned RequestsPerPhase = 45;
  localparam logic [2:0] SlaveAddrOffset = {RegSlaveAddr, 2'b00};

  // One directed request; a typed row carries the whole read frame, first byte on top
  typedef struct packed {
    request_t    req;
    logic        typed;
    logic [63:0] frame;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  request_t    request;
  result_t     result;
  logic        result_strobe;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [7:0]  slave_cfg;
  result_t     frame_bytes_due [$];
  int unsigned error_count;
  bit          idle_enable;

  stim_row_t directed_rows [0:13] = '{
    '{'{OpRead,  16'h0000, 16'h0000}, 1'b1, 64'h0103_0000_0001_840A},
    '{'{OpRead,  16'h0001, 16'h0000}, 1'b0, 64'h0},
    '{'{OpRead,  16'hFFFF, 16'hFFFF}, 1'b0, 64'h0},
    '{'{OpRead,  16'h0000, 16'hFFFF}, 1'b0, 64'h0},
    '{'{OpRead,  16'hFFFF, 16'h0000}, 1'b0, 64'h0},
    '{'{OpWrite, 16'h0000, 16'h0000}, 1'b0, 64'h0},
    '{'{OpWrite, 16'hFFFF, 16'hFFFF}, 1'b0, 64'h0},
    '{'{OpWrite, 16'h0000, 16'hFFFF}, 1'b0, 64'h0},
    '{'{OpWrite, 16'hFFFF, 16'h0000}, 1'b0, 64'h0},
    '{'{OpWrite, 16'hAAAA, 16'h5555}, 1'b0, 64'h0},
    '{'{OpRead,  16'h5555, 16'hAAAA}, 1'b0, 64'h0},
    '{'{OpWrite, 16'h8000, 16'h0001}, 1'b0, 64'h0},
    '{'{OpRead,  16'h0180, 16'h1234}, 1'b0, 64'h0},
    '{'{OpWrite, 16'h1234, 16'hABCD}, 1'b0, 64'h0}
  };

  modbus_rtu_request_framer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .request_i       (request),
    .result_o        (result),
    .result_strobe_o (result_strobe),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the CRC-16/MODBUS by one byte, LSB first
  function automatic logic [15:0] crc_modbus_next(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    logic        feedback;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      feedback = acc[0] ^ data[i];
      acc = {1'b0, acc[15:1]};
      if (feedback) begin
        acc = acc ^ CrcPoly;
      end
    end
    return acc;
  endfunction

  function automatic request_t random_request();
    request_t req;
    req.opcode = 1'($urandom_range(1));
    req.register_address = 16'($urandom);
    req.write_value = 16'($urandom);
    // Pull the address to an extreme now and then
    case ($urandom_range(7))
      0: req.register_address = 16'h0000;
      1: req.register_address = 16'hFFFF;
      default: ;
    endcase
    return req;
  endfunction

  // Build the frame for one request and queue its bytes in transmit order
  task automatic queue_frame(input request_t req);
    logic [7:0]  body [$];
    logic [15:0] crc;
    result_t     entry;
    body.push_back(slave_cfg);
    body.push_back((req.opcode == OpWrite) ? FuncWriteMultiple : FuncReadHolding);
    body.push_back(req.register_address[15:8]);
    body.push_back(req.register_address[7:0]);
    body.push_back(CountHigh);
    body.push_back(CountLow);
    if (req.opcode == OpWrite) begin
      body.push_back(WriteByteCount);
      body.push_back(req.write_value[15:8]);
      body.push_back(req.write_value[7:0]);
    end
    crc = CrcInit;
    foreach (body[k]) begin
      crc = crc_modbus_next(crc, body[k]);
    end
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    foreach (body[k]) begin
      entry.frame_byte = body[k];
      entry.last_byte = (k == body.size() - 1);
      frame_bytes_due.push_back(entry);
    end
  endtask

  // Hold start and the request until the block takes it; returns at the accepting edge
  task automatic send_request(input request_t req);
    @(negedge clk_i);
    while (idle_enable && $urandom_range(99) < 33) begin
      start = 1'b0;
      request = random_request();
      @(negedge clk_i);
    end
    start = 1'b1;
    request = req;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
  endtask

  // Drop start, let every queued byte come out, then give the block time to settle
  task automatic wait_frames_done();
    @(negedge clk_i);
    start = 1'b0;
    while (frame_bytes_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the slave address, then read it back
  task automatic write_slave_address(input logic [7:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = SlaveAddrOffset;
    pwdata = {24'd0, value};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    slave_cfg = value;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    if (prdata[7:0] !== value) begin
      $display("%0t slave address read back: expected %h actual %h", $time, value, prdata[7:0]);
      error_count++;
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Compare every strobed byte against the oldest queued one
  always @(posedge clk_i) begin : check_bytes
    result_t want;
    if (rst_ni && result_strobe === 1'b1) begin
      if (frame_bytes_due.size() == 0) begin
        $display("%0t unexpected byte: expected none actual %h last %b", $time,
                 result.frame_byte, result.last_byte);
        error_count++;
      end else begin
        want = frame_bytes_due.pop_front();
        if (result.frame_byte !== want.frame_byte) begin
          $display("%0t frame_byte: expected %h actual %h", $time, want.frame_byte,
                   result.frame_byte);
          error_count++;
        end
        if (result.last_byte !== want.last_byte) begin
          $display("%0t last_byte: expected %b actual %b", $time, want.last_byte,
                   result.last_byte);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    result_t  entry;
    logic [7:0] slave;
    rst_ni = 1'b0;
    start = 1'b0;
    request = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    slave_cfg = 8'd1;
    error_count = 0;
    idle_enable = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed requests under the reset slave address
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req);
      if (directed_rows[i].typed) begin
        for (int k = 0; k < 8; k++) begin
          entry.frame_byte = directed_rows[i].frame[63 - 8 * k -: 8];
          entry.last_byte = (k == 7);
          frame_bytes_due.push_back(entry);
        end
      end else begin
        queue_frame(directed_rows[i].req);
      end
    end

    // Random requests, one slave address per phase; the second phase runs without gaps
    for (int phase = 0; phase < PhaseCount; phase++) begin
      wait_frames_done();
      case (phase)
        0: slave = 8'h00;
        1: slave = 8'hFF;
        4: slave = 8'hF7;
        default: slave = 8'($urandom);
      endcase
      write_slave_address(slave);
      idle_enable = (phase != 1);
      for (int n = 0; n < RequestsPerPhase; n++) begin
        send_request(random_request());
        queue_frame(request);
      end
    end

    wait_frames_done();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
